>>> rtl/core/gegf_pkg.sv
// ----------------------------------------------------------------------------
// gegf_pkg
// Shared types and constants for the gradient edge glow filter.
// ----------------------------------------------------------------------------
package gegf_pkg;

    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int GAIN_W     = 3;
    localparam int BOR_W      = 3;
    localparam int CH_W       = 16;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_GAIN   = 5;
    localparam int ROOT_STEPS = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CH_W-1:0] FULL_8  = 16'd255;
    localparam logic [CH_W-1:0] FULL_16 = 16'd65535;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEEP_SAMPLES = 3'd5;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [FW_W-1:0]   frame_width;
        logic [FH_W-1:0]   frame_height;
        logic [GAIN_W-1:0] intensity;
        logic [BOR_W-1:0]  border_width;
        logic              edge_mode;
        logic              deep_samples;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_HERE,
        S_RD_RIGHT,
        S_RD_BELOW,
        S_LAT_BELOW,
        S_DIFF,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        RSEL_HERE,
        RSEL_RIGHT,
        RSEL_BELOW
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    lat_here;
        logic    lat_right;
        logic    lat_below;
        logic    diff;
        logic    square;
        logic    sum;
        logic    root_step;
        logic    load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic will_emit;
        logic root_last;
        logic out_busy;
    } ctrl_status_t;

endpackage

>>> rtl/core/gradient_edge_glow_filter_unit.sv
// ----------------------------------------------------------------------------
// gradient_edge_glow_filter_unit
// Gradient magnitude edge filter (glow / find edges) on a raster RGB stream.
//
//   channel  signals                              direction
//   cfg      cfg_valid cfg_ready cfg_index cfg_data   write in
//   in       in_valid in_stall cmd red/green/blue_in  item in
//   out      out_valid out_stall red/green/blue_out frame_end   result out
//
// An item without a result is taken in the idle state; an item with a result
// runs through 3 row store reads, difference, square, sum, 16 root steps and load.
// The 16-step bit-serial square root is the longest part of that sequence.
// Reset is asynchronous, active low; the row store holds no reset.
// A result waits in the output register; out_stall holds it there and
// stalls the sequencer only once the next result is ready.
// ----------------------------------------------------------------------------
module gradient_edge_glow_filter_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_BORDER = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gegf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gegf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [gegf_pkg::CH_W-1:0]         red_in,
    input  logic [gegf_pkg::CH_W-1:0]         green_in,
    input  logic [gegf_pkg::CH_W-1:0]         blue_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gegf_pkg::CH_W-1:0]         red_out,
    output logic [gegf_pkg::CH_W-1:0]         green_out,
    output logic [gegf_pkg::CH_W-1:0]         blue_out,
    output logic                              frame_end
);

    gegf_pkg::cfg_t         cfg_reg, cfg_next;
    gegf_pkg::ctrl_cmd_t    ctl_cmd;
    gegf_pkg::ctrl_status_t ctl_status;
    logic                   cfg_wr;
    logic                   geo_restart;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next    = cfg_reg;
        geo_restart = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                gegf_pkg::REG_FRAME_WIDTH:
                begin
                    cfg_next.frame_width = cfg_data[gegf_pkg::FW_W-1:0];
                    geo_restart          = 1'b1;
                end
                gegf_pkg::REG_FRAME_HEIGHT:
                begin
                    cfg_next.frame_height = cfg_data[gegf_pkg::FH_W-1:0];
                    geo_restart           = 1'b1;
                end
                gegf_pkg::REG_INTENSITY:
                    cfg_next.intensity = cfg_data[gegf_pkg::GAIN_W-1:0];
                gegf_pkg::REG_BORDER_WIDTH:
                begin
                    cfg_next.border_width = cfg_data[gegf_pkg::BOR_W-1:0];
                    geo_restart           = 1'b1;
                end
                gegf_pkg::REG_EDGE_MODE:
                    cfg_next.edge_mode = cfg_data[0];
                gegf_pkg::REG_DEEP_SAMPLES:
                    cfg_next.deep_samples = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= 12'd640;
            cfg_reg.frame_height <= 13'd480;
            cfg_reg.intensity    <= 3'd0;
            cfg_reg.border_width <= 3'd1;
            cfg_reg.edge_mode    <= 1'b1;
            cfg_reg.deep_samples <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gegf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (ctl_status),
        .cmd      (ctl_cmd)
    );

    gegf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_BORDER (MAX_BORDER)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .geo_restart (geo_restart),
        .cmd         (ctl_cmd),
        .status      (ctl_status),
        .in_cmd      (cmd),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .frame_end   (frame_end)
    );

    // a result is loaded only from the busy sequencer
    a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result loaded while input side was open");

    // a result is preceded by a stalled input side earlier in the sequence
    a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall, 5))
        else $error("result appeared too soon");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result in cycle after transaction");

endmodule

>>> rtl/core/gegf_ram.sv
// ----------------------------------------------------------------------------
// gegf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gegf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 12288
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/gegf_ctrl.sv
// ----------------------------------------------------------------------------
// gegf_ctrl
// Sequencer: accept, three store reads, difference, square, sum, root, output.
// ----------------------------------------------------------------------------
module gegf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  gegf_pkg::ctrl_status_t status,
    output gegf_pkg::ctrl_cmd_t    cmd
);

    gegf_pkg::state_t state_reg;
    gegf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gegf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gegf_pkg::S_IDLE:
            begin
                if (in_valid && status.will_emit)
                begin
                    state_next = gegf_pkg::S_RD_HERE;
                end
            end
            gegf_pkg::S_RD_HERE:   state_next = gegf_pkg::S_RD_RIGHT;
            gegf_pkg::S_RD_RIGHT:  state_next = gegf_pkg::S_RD_BELOW;
            gegf_pkg::S_RD_BELOW:  state_next = gegf_pkg::S_LAT_BELOW;
            gegf_pkg::S_LAT_BELOW: state_next = gegf_pkg::S_DIFF;
            gegf_pkg::S_DIFF:      state_next = gegf_pkg::S_SQUARE;
            gegf_pkg::S_SQUARE:    state_next = gegf_pkg::S_SUM;
            gegf_pkg::S_SUM:       state_next = gegf_pkg::S_ROOT;
            gegf_pkg::S_ROOT:
            begin
                if (status.root_last)
                begin
                    state_next = gegf_pkg::S_OUT;
                end
            end
            gegf_pkg::S_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = gegf_pkg::S_IDLE;
                end
            end
            default: state_next = gegf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.rd_sel = gegf_pkg::RSEL_HERE;
        in_stall = 1'b1;
        unique case (state_reg)
            gegf_pkg::S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            gegf_pkg::S_RD_HERE:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = gegf_pkg::RSEL_HERE;
            end
            gegf_pkg::S_RD_RIGHT:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = gegf_pkg::RSEL_RIGHT;
                cmd.lat_here = 1'b1;
            end
            gegf_pkg::S_RD_BELOW:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = gegf_pkg::RSEL_BELOW;
                cmd.lat_right = 1'b1;
            end
            gegf_pkg::S_LAT_BELOW: cmd.lat_below = 1'b1;
            gegf_pkg::S_DIFF:      cmd.diff      = 1'b1;
            gegf_pkg::S_SQUARE:    cmd.square    = 1'b1;
            gegf_pkg::S_SUM:       cmd.sum       = 1'b1;
            gegf_pkg::S_ROOT:      cmd.root_step = 1'b1;
            gegf_pkg::S_OUT:       cmd.load_out  = !status.out_busy;
            default:               cmd.accept    = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/gegf_datapath.sv
// ----------------------------------------------------------------------------
// gegf_datapath
// Position counters, row store, gradient arithmetic, bit-serial root, output.
// ----------------------------------------------------------------------------
module gegf_datapath #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_BORDER = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gegf_pkg::cfg_t                cfg,
    input  logic                          geo_restart,
    input  gegf_pkg::ctrl_cmd_t           cmd,
    output gegf_pkg::ctrl_status_t        status,
    input  logic                          in_cmd,
    input  logic [gegf_pkg::CH_W-1:0]     red_in,
    input  logic [gegf_pkg::CH_W-1:0]     green_in,
    input  logic [gegf_pkg::CH_W-1:0]     blue_in,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [gegf_pkg::CH_W-1:0]     red_out,
    output logic [gegf_pkg::CH_W-1:0]     green_out,
    output logic [gegf_pkg::CH_W-1:0]     blue_out,
    output logic                          frame_end
);

    localparam int SROWS = MAX_BORDER + 1;
    localparam int DEPTH = SROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SW    = $clog2(SROWS);
    localparam int MW    = SW + 4;
    localparam int RW    = gegf_pkg::ROW_W;
    localparam int HW    = gegf_pkg::FH_W;
    localparam int BW    = gegf_pkg::BOR_W;
    localparam int CH    = gegf_pkg::CH_W;
    localparam int NCH   = gegf_pkg::NUM_CH;

    function automatic logic [SW-1:0] sub_mod(input logic [SW-1:0] a, input logic [BW-1:0] b);
        logic [MW-1:0] t;
        t = MW'(a) + MW'(SROWS) - MW'(b);
        if (t >= MW'(SROWS))
        begin
            t = t - MW'(SROWS);
        end
        return SW'(t);
    endfunction

    function automatic logic [SW-1:0] add_mod(input logic [SW-1:0] a, input logic [BW-1:0] b);
        logic [MW-1:0] t;
        t = MW'(a) + MW'(b);
        if (t >= MW'(SROWS))
        begin
            t = t - MW'(SROWS);
        end
        return SW'(t);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [CW-1:0] c);
        return AW'(32'(s) * MAX_WIDTH) + AW'(c);
    endfunction

    // effective geometry
    logic [WW-1:0]                 eff_w;
    logic [HW-1:0]                 eff_h;
    logic [BW-1:0]                 eff_b;
    logic [gegf_pkg::GAIN_W-1:0]   gain;
    logic [BW-1:0]                 m_rows;

    always_comb
    begin
        if (cfg.frame_width == '0)
            eff_w = WW'(1);
        else if (32'(cfg.frame_width) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(cfg.frame_width);

        if (cfg.frame_height == '0)
            eff_h = HW'(1);
        else if (32'(cfg.frame_height) > gegf_pkg::MAX_HEIGHT)
            eff_h = HW'(gegf_pkg::MAX_HEIGHT);
        else
            eff_h = cfg.frame_height;

        if (cfg.border_width == '0)
            eff_b = BW'(1);
        else if (32'(cfg.border_width) > MAX_BORDER)
            eff_b = BW'(MAX_BORDER);
        else
            eff_b = cfg.border_width;

        gain = (32'(cfg.intensity) > gegf_pkg::MAX_GAIN) ?
               gegf_pkg::GAIN_W'(gegf_pkg::MAX_GAIN) : cfg.intensity;
        m_rows = (eff_h < HW'(eff_b)) ? BW'(eff_h) : eff_b;
    end

    // position state
    logic [CW-1:0] col_reg,    col_next;
    logic [RW-1:0] row_reg,    row_next;
    logic [SW-1:0] wslot_reg,  wslot_next;
    logic          drain_reg,  drain_next;
    logic [CW-1:0] dcol_reg,   dcol_next;
    logic [RW-1:0] drow_reg,   drow_next;
    logic [SW-1:0] dslot_reg,  dslot_next;

    logic          pixel_ok;
    logic          drain_ok;
    logic [CW-1:0] src_col;
    logic [WW-1:0] rem_c;
    logic [WW-1:0] dx;
    logic [HW-1:0] rem_h;
    logic [BW-1:0] dy;
    logic          col_last;
    logic          row_last;
    logic          dcol_last;
    logic          drow_last;
    logic          will_emit;

    always_comb
    begin
        pixel_ok  = (in_cmd == gegf_pkg::CMD_PIXEL) && !drain_reg;
        drain_ok  = (in_cmd == gegf_pkg::CMD_DRAIN) && drain_reg;
        src_col   = drain_ok ? dcol_reg : col_reg;
        rem_c     = eff_w - WW'(1) - WW'(src_col);
        dx        = (rem_c < WW'(eff_b)) ? rem_c : WW'(eff_b);
        rem_h     = eff_h - HW'(1) - HW'(drow_reg);
        dy        = (rem_h < HW'(eff_b)) ? BW'(rem_h) : eff_b;
        col_last  = (WW'(col_reg) == eff_w - WW'(1));
        row_last  = (HW'(row_reg) == eff_h - HW'(1));
        dcol_last = (WW'(dcol_reg) == eff_w - WW'(1));
        drow_last = (HW'(drow_reg) == eff_h - HW'(1));
        will_emit = pixel_ok ? (row_reg >= RW'(eff_b)) : drain_ok;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        wslot_next = wslot_reg;
        drain_next = drain_reg;
        dcol_next  = dcol_reg;
        drow_next  = drow_reg;
        dslot_next = dslot_reg;
        if (geo_restart)
        begin
            col_next   = '0;
            row_next   = '0;
            wslot_next = '0;
            drain_next = 1'b0;
        end
        else if (cmd.accept && pixel_ok)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (row_last)
                begin
                    row_next   = '0;
                    wslot_next = '0;
                    drain_next = 1'b1;
                    dcol_next  = '0;
                    drow_next  = RW'(eff_h - HW'(m_rows));
                    dslot_next = sub_mod(wslot_reg, m_rows - BW'(1));
                end
                else
                begin
                    row_next   = row_reg + RW'(1);
                    wslot_next = add_mod(wslot_reg, BW'(1));
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        else if (cmd.accept && drain_ok)
        begin
            if (dcol_last && drow_last)
            begin
                drain_next = 1'b0;
            end
            else if (dcol_last)
            begin
                dcol_next  = '0;
                drow_next  = drow_reg + RW'(1);
                dslot_next = add_mod(dslot_reg, BW'(1));
            end
            else
            begin
                dcol_next = dcol_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            wslot_reg <= '0;
            drain_reg <= 1'b0;
            dcol_reg  <= '0;
            drow_reg  <= '0;
            dslot_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            wslot_reg <= wslot_next;
            drain_reg <= drain_next;
            dcol_reg  <= dcol_next;
            drow_reg  <= drow_next;
            dslot_reg <= dslot_next;
        end
    end

    // target of the pending result
    logic [CW-1:0] ecol_reg;
    logic [CW-1:0] ercol_reg;
    logic [SW-1:0] erslot_reg;
    logic [SW-1:0] ebslot_reg;
    logic          elast_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && will_emit)
        begin
            ecol_reg  <= src_col;
            ercol_reg <= CW'(WW'(src_col) + dx);
            if (drain_ok)
            begin
                erslot_reg <= dslot_reg;
                ebslot_reg <= add_mod(dslot_reg, dy);
                elast_reg  <= dcol_last && drow_last;
            end
            else
            begin
                erslot_reg <= sub_mod(wslot_reg, eff_b);
                ebslot_reg <= wslot_reg;
                elast_reg  <= 1'b0;
            end
        end
    end

    // row store
    logic [AW-1:0]                 raddr;
    logic [gegf_pkg::PIX_W-1:0]    rdata;

    always_comb
    begin
        unique case (cmd.rd_sel)
            gegf_pkg::RSEL_HERE:  raddr = addr_of(erslot_reg, ecol_reg);
            gegf_pkg::RSEL_RIGHT: raddr = addr_of(erslot_reg, ercol_reg);
            gegf_pkg::RSEL_BELOW: raddr = addr_of(ebslot_reg, ecol_reg);
            default:              raddr = addr_of(erslot_reg, ecol_reg);
        endcase
    end

    gegf_ram #(
        .WIDTH (gegf_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (cmd.accept && pixel_ok),
        .waddr (addr_of(wslot_reg, col_reg)),
        .wdata ({blue_in, green_in, red_in}),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // arithmetic lanes
    logic [gegf_pkg::PIX_W-1:0] here_reg;
    logic [gegf_pkg::PIX_W-1:0] right_reg;
    logic [gegf_pkg::PIX_W-1:0] below_reg;
    logic [CH-1:0]              d1_reg   [NCH];
    logic [CH-1:0]              d2_reg   [NCH];
    logic [2*CH-1:0]            sq1_reg  [NCH];
    logic [2*CH-1:0]            sq2_reg  [NCH];
    logic                       sat_reg  [NCH];
    logic [2*CH-1:0]            vsh_reg  [NCH];
    logic [CH+3:0]              rem_reg  [NCH];
    logic [CH-1:0]              root_reg [NCH];
    logic [4:0]                 cnt_reg;
    logic [CH-1:0]              full;

    assign full = cfg.deep_samples ? gegf_pkg::FULL_16 : gegf_pkg::FULL_8;

    always_ff @(posedge clk)
    begin
        if (cmd.lat_here)
            here_reg <= rdata;
        if (cmd.lat_right)
            right_reg <= rdata;
        if (cmd.lat_below)
            below_reg <= rdata;
        if (cmd.sum)
            cnt_reg <= '0;
        else if (cmd.root_step)
            cnt_reg <= cnt_reg + 5'd1;
    end

    for (genvar k = 0; k < NCH; k++)
    begin : g_lane
        logic [CH-1:0]     p, q1, q2;
        logic [2*CH+5:0]   xs;
        logic [CH+3:0]     remx, trial;

        always_comb
        begin
            if (cfg.deep_samples)
            begin
                p  = here_reg[CH*k +: CH];
                q1 = right_reg[CH*k +: CH];
                q2 = below_reg[CH*k +: CH];
            end
            else
            begin
                p  = CH'(here_reg[CH*k +: 8]);
                q1 = CH'(right_reg[CH*k +: 8]);
                q2 = CH'(below_reg[CH*k +: 8]);
            end
            xs    = (38'(sq1_reg[k]) + 38'(sq2_reg[k])) << gain;
            remx  = {rem_reg[k][CH+1:0], vsh_reg[k][2*CH-1 -: 2]};
            trial = {2'b00, root_reg[k], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (cmd.diff)
            begin
                d1_reg[k] <= (p > q1) ? p - q1 : q1 - p;
                d2_reg[k] <= (p > q2) ? p - q2 : q2 - p;
            end
            if (cmd.square)
            begin
                sq1_reg[k] <= d1_reg[k] * d1_reg[k];
                sq2_reg[k] <= d2_reg[k] * d2_reg[k];
            end
            if (cmd.sum)
            begin
                sat_reg[k]  <= cfg.deep_samples ? (xs[37:32] != '0) : (xs[37:16] != '0);
                vsh_reg[k]  <= xs[2*CH-1:0];
                rem_reg[k]  <= '0;
                root_reg[k] <= '0;
            end
            else if (cmd.root_step)
            begin
                vsh_reg[k] <= {vsh_reg[k][2*CH-3:0], 2'b00};
                if (remx >= trial)
                begin
                    rem_reg[k]  <= remx - trial;
                    root_reg[k] <= {root_reg[k][CH-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= remx;
                    root_reg[k] <= {root_reg[k][CH-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    logic [CH-1:0] res [NCH];
    logic [CH-1:0] red_reg, green_reg, blue_reg;
    logic          fend_reg;
    logic          ovalid_reg;

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            res[k] = sat_reg[k] ? full : root_reg[k];
            if (!cfg.edge_mode)
                res[k] = full - res[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            red_reg   <= res[0];
            green_reg <= res[1];
            blue_reg  <= res[2];
            fend_reg  <= elast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.load_out)
            ovalid_reg <= 1'b1;
        else if (!out_stall)
            ovalid_reg <= 1'b0;
    end

    assign out_valid        = ovalid_reg;
    assign red_out          = red_reg;
    assign green_out        = green_reg;
    assign blue_out         = blue_reg;
    assign frame_end        = fend_reg;
    assign status.will_emit = will_emit;
    assign status.root_last = (cnt_reg == 5'(gegf_pkg::ROOT_STEPS - 1));
    assign status.out_busy  = ovalid_reg && out_stall;

endmodule

>>> dv/gradient_edge_glow_filter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_edge_glow_filter_unit_test
// Self-checking bench for the gradient edge glow filter. A scoreboard class
// keeps its own line store, frame counters and registers, predicts each
// output pixel as input transactions are accepted, and compares every output
// transaction field by field in order. Stimulus: a directed frame set, then
// random small frames with noise, two saturating large frames, and phases of
// random idling, stalling and back pressure on both channels.
// ----------------------------------------------------------------------------
module gradient_edge_glow_filter_unit_test;

    localparam int  LINE_MAX    = 2048;
    localparam int  BORDER_MAX  = 5;
    localparam int  STORE_LINES = BORDER_MAX + 1;
    localparam int  SETTLE      = 40;
    localparam int  RAND_ITEMS  = 1850;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [gegf_pkg::CH_W-1:0] red;
        logic [gegf_pkg::CH_W-1:0] green;
        logic [gegf_pkg::CH_W-1:0] blue;
        logic                      last;
    } glow_px_t;

    class glow_scoreboard;
        logic [gegf_pkg::PIX_W-1:0] line_store [STORE_LINES*LINE_MAX];
        int unsigned col, row, drain_left;
        int unsigned fw, fh, gain, border;
        bit glow, deep;
        glow_px_t pending_px [$];
        int errors;

        function new();
            foreach (line_store[i]) line_store[i] = '0;
            col = 0; row = 0; drain_left = 0;
            fw = 640; fh = 480; gain = 0; border = 1; glow = 1; deep = 0;
            errors = 0;
        endfunction

        function int unsigned eff_w();
            if (fw == 0) return 1;
            return fw > LINE_MAX ? LINE_MAX : fw;
        endfunction

        function int unsigned eff_h();
            if (fh == 0) return 1;
            return fh > gegf_pkg::MAX_HEIGHT ? gegf_pkg::MAX_HEIGHT : fh;
        endfunction

        function int unsigned eff_b();
            if (border == 0) return 1;
            return border > BORDER_MAX ? BORDER_MAX : border;
        endfunction

        function int unsigned slot(int unsigned r, int unsigned c);
            return (r % STORE_LINES) * LINE_MAX + (c % LINE_MAX);
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned res, trial;
            res = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = res | (64'd1 << b);
                if (trial * trial <= v) res = trial;
            end
            return res;
        endfunction

        function void write_reg(logic [gegf_pkg::CFG_IDX_W-1:0] idx,
                                logic [gegf_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                gegf_pkg::REG_FRAME_WIDTH:  fw = data[gegf_pkg::FW_W-1:0];
                gegf_pkg::REG_FRAME_HEIGHT: fh = data[gegf_pkg::FH_W-1:0];
                gegf_pkg::REG_INTENSITY:    gain = data[gegf_pkg::GAIN_W-1:0];
                gegf_pkg::REG_BORDER_WIDTH: border = data[gegf_pkg::BOR_W-1:0];
                gegf_pkg::REG_EDGE_MODE:    glow = data[0];
                gegf_pkg::REG_DEEP_SAMPLES: deep = data[0];
                default: ;
            endcase
            if (idx == gegf_pkg::REG_FRAME_WIDTH || idx == gegf_pkg::REG_FRAME_HEIGHT ||
                idx == gegf_pkg::REG_BORDER_WIDTH)
            begin
                col = 0; row = 0; drain_left = 0;
            end
        endfunction

        function void gradient_px(int unsigned r, int unsigned c, bit last);
            int unsigned w, h, b, dx, dy, g;
            logic [gegf_pkg::PIX_W-1:0] here, right, below;
            longint unsigned p, q1, q2, d1, d2, s, full, mask;
            logic [gegf_pkg::CH_W-1:0] ch [3];
            glow_px_t px;
            w = eff_w(); h = eff_h(); b = eff_b();
            dx = (w - 1 - c) < b ? (w - 1 - c) : b;
            dy = (h - 1 - r) < b ? (h - 1 - r) : b;
            here = line_store[slot(r, c)];
            right = line_store[slot(r, c + dx)];
            below = line_store[slot(r + dy, c)];
            mask = deep ? 64'hFFFF : 64'hFF;
            full = deep ? 65535 : 255;
            g = gain > gegf_pkg::MAX_GAIN ? gegf_pkg::MAX_GAIN : gain;
            for (int k = 0; k < 3; k++) begin
                p = (here >> (16 * k)) & mask;
                q1 = (right >> (16 * k)) & mask;
                q2 = (below >> (16 * k)) & mask;
                d1 = p > q1 ? p - q1 : q1 - p;
                d2 = p > q2 ? p - q2 : q2 - p;
                s = floor_root((d1 * d1 + d2 * d2) << g);
                if (s > full) s = full;
                if (!glow) s = full - s;
                ch[k] = s[gegf_pkg::CH_W-1:0];
            end
            px.red = ch[0]; px.green = ch[1]; px.blue = ch[2]; px.last = last;
            pending_px.push_back(px);
        endfunction

        // returns 1 when the transaction does work, 0 when it is ignored
        function bit note_input(logic c, logic [gegf_pkg::CH_W-1:0] r,
                                logic [gegf_pkg::CH_W-1:0] g,
                                logic [gegf_pkg::CH_W-1:0] bl);
            int unsigned w, h, b, m, p;
            w = eff_w(); h = eff_h(); b = eff_b();
            m = h < b ? h : b;
            if (c == gegf_pkg::CMD_PIXEL) begin
                if (drain_left != 0) return 0;
                line_store[slot(row, col)] = {bl, g, r};
                if (row >= b) gradient_px(row - b, col, 0);
                if (col + 1 >= w) begin
                    col = 0;
                    if (row + 1 >= h) begin
                        row = 0;
                        drain_left = m * w;
                    end
                    else row++;
                end
                else col++;
                return 1;
            end
            if (drain_left == 0) return 0;
            p = m * w - drain_left;
            gradient_px(h - m + p / w, p % w, drain_left == 1);
            drain_left--;
            return 1;
        endfunction

        function void check_result(logic [gegf_pkg::CH_W-1:0] r,
                                   logic [gegf_pkg::CH_W-1:0] g,
                                   logic [gegf_pkg::CH_W-1:0] bl, logic fe);
            glow_px_t e;
            if (pending_px.size() == 0) begin
                $error("unexpected output transaction %0h %0h %0h %0b", r, g, bl, fe);
                errors++;
                return;
            end
            e = pending_px.pop_front();
            if (r !== e.red) begin
                $error("red_out: expected %0h, got %0h", e.red, r); errors++;
            end
            if (g !== e.green) begin
                $error("green_out: expected %0h, got %0h", e.green, g); errors++;
            end
            if (bl !== e.blue) begin
                $error("blue_out: expected %0h, got %0h", e.blue, bl); errors++;
            end
            if (fe !== e.last) begin
                $error("frame_end: expected %0b, got %0b", e.last, fe); errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gegf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gegf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = gegf_pkg::CMD_PIXEL;
    logic [gegf_pkg::CH_W-1:0] red_in = '0, green_in = '0, blue_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [gegf_pkg::CH_W-1:0] red_out, green_out, blue_out;
    logic frame_end;

    glow_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int work_items = 0;
    longint cycles = 0;

    gradient_edge_glow_filter_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .frame_end(frame_end)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** gradient_edge_glow_filter_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(red_out, green_out, blue_out, frame_end);
        if (hold_req > 0 && hold_left == 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else out_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
    end

    task automatic send_item(logic c, logic [gegf_pkg::CH_W-1:0] r,
                             logic [gegf_pkg::CH_W-1:0] g,
                             logic [gegf_pkg::CH_W-1:0] b);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c; red_in <= r; green_in <= g; blue_in <= b;
        do @(posedge clk); while (in_stall);
        if (sb.note_input(c, r, g, b)) work_items++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_px.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [gegf_pkg::CFG_IDX_W-1:0] idx, int unsigned val,
                             int fbits);
        logic [gegf_pkg::CFG_DATA_W-1:0] data;
        data = 16'($urandom);
        data = (data & ~((16'd1 << fbits) - 16'd1)) | val[gegf_pkg::CFG_DATA_W-1:0];
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned g,
                             int unsigned b, bit gl, bit dp);
        wait_idle();
        write_reg(gegf_pkg::REG_FRAME_WIDTH, w, gegf_pkg::FW_W);
        write_reg(gegf_pkg::REG_FRAME_HEIGHT, h, gegf_pkg::FH_W);
        write_reg(gegf_pkg::REG_INTENSITY, g, gegf_pkg::GAIN_W);
        write_reg(gegf_pkg::REG_BORDER_WIDTH, b, gegf_pkg::BOR_W);
        write_reg(gegf_pkg::REG_EDGE_MODE, gl, 1);
        write_reg(gegf_pkg::REG_DEEP_SAMPLES, dp, 1);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [gegf_pkg::CH_W-1:0] sample(logic [gegf_pkg::CH_W-1:0] base);
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 16'($urandom);
            default: return 16'(base + $urandom_range(40) - 20);
        endcase
    endfunction

    task automatic run_frame(bit noisy);
        int unsigned n, cut;
        logic [gegf_pkg::CH_W-1:0] base;
        base = 16'($urandom);
        n = sb.eff_w() * sb.eff_h();
        cut = (noisy && $urandom_range(19) == 0) ? $urandom_range(n) : n + 1;
        for (int unsigned i = 0; i < n; i++) begin
            if (i == cut) return;
            if (noisy && $urandom_range(19) == 0)
                send_item(gegf_pkg::CMD_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom));
            send_item(gegf_pkg::CMD_PIXEL, sample(base), sample(base), sample(base));
        end
        while (sb.drain_left > 0) begin
            if (noisy && $urandom_range(19) == 0) begin
                if (cut != n + 1) return;
                send_item(gegf_pkg::CMD_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom));
            end
            send_item(gegf_pkg::CMD_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        if (noisy && $urandom_range(9) == 0)
            send_item(gegf_pkg::CMD_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_frame();
        int unsigned w, h;
        w = $urandom_range(19) == 0 ? 0 : $urandom_range(1, 12);
        h = $urandom_range(19) == 0 ? 0 : $urandom_range(1, 7);
        set_frame(w, h, $urandom_range(7), $urandom_range(7), 1'($urandom), 1'($urandom));
        run_frame(1'b1);
    endtask

    initial begin
        int start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frame(4, 2, 0, 1, 1'b1, 1'b1);
        send_item(gegf_pkg::CMD_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(gegf_pkg::CMD_PIXEL, 16'h0000, 16'hFFFF, 16'h5555);
        send_item(gegf_pkg::CMD_PIXEL, 16'hFFFF, 16'h0000, 16'hAAAA);
        send_item(gegf_pkg::CMD_PIXEL, 16'h5555, 16'hAAAA, 16'h0000);
        send_item(gegf_pkg::CMD_PIXEL, 16'hAAAA, 16'h5555, 16'hFFFF);
        send_item(gegf_pkg::CMD_PIXEL, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(gegf_pkg::CMD_PIXEL, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(gegf_pkg::CMD_PIXEL, 16'h00FF, 16'hFF00, 16'h8001);
        send_item(gegf_pkg::CMD_PIXEL, 16'hFF00, 16'h00FF, 16'h7FFE);
        send_item(gegf_pkg::CMD_PIXEL, 16'h1234, 16'h1234, 16'h1234);
        repeat (4) send_item(gegf_pkg::CMD_DRAIN, '0, '0, '0);
        send_item(gegf_pkg::CMD_DRAIN, '0, '0, '0);
        set_frame(2, 1, 7, 5, 1'b0, 1'b0);
        send_item(gegf_pkg::CMD_PIXEL, 16'h00FF, 16'h0000, 16'hFF80);
        send_item(gegf_pkg::CMD_PIXEL, 16'h0000, 16'h00FF, 16'h007F);
        repeat (2) send_item(gegf_pkg::CMD_DRAIN, '0, '0, '0);
        set_frame(0, 0, 6, 0, 1'b1, 1'b0);
        send_item(gegf_pkg::CMD_PIXEL, 16'hABCD, 16'h0102, 16'hFFFF);
        send_item(gegf_pkg::CMD_DRAIN, '0, '0, '0);

        work_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct = ph == 1 ? 75 : ph == 3 ? 33 : 0;
            rx_stall_pct = ph == 2 ? 75 : ph == 3 ? 33 : 0;
            start = work_items;
            while (work_items - start < RAND_ITEMS / 4) begin
                random_frame();
                if ($urandom_range(7) == 0) begin
                    tx_idle_pct = tx_idle_pct == 0 ? 0 : 0;
                    rx_stall_pct = 0;
                    random_frame();
                    tx_idle_pct = ph == 1 ? 75 : ph == 3 ? 33 : 0;
                    rx_stall_pct = ph == 2 ? 75 : ph == 3 ? 33 : 0;
                end
            end
            if (ph == 0) begin
                set_frame(12, 6, 3, 2, 1'b1, 1'b1);
                hold_req = 3000;
                run_frame(1'b0);
                wait_idle();
                set_frame(4095, 1, 5, 1, 1'b1, 1'b1);
                run_frame(1'b0);
                set_frame(1, 8191, 2, 5, 1'b0, 1'b1);
                run_frame(1'b0);
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_px.size() == 0)
            $display("** gradient_edge_glow_filter_unit: PASSED **");
        else
            $display("** gradient_edge_glow_filter_unit: FAILED **");
        $finish;
    end

endmodule
